@@ hw/rtl/m2m_pkg.sv @@
// m2m_pkg: shared types, opcodes, request codes and the address wrap table
// for the memory-to-memory processor. No dependencies.
`timescale 1ns / 1ps

package m2m_pkg;

  // memory geometry
  localparam int MEM_DEPTH = 256;
  localparam int WORD_BITS = 32;
  localparam int ADDR_BITS = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // request codes
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_EXEC = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // opcodes
  localparam logic [7:0] OP_NOP  = 8'd0;
  localparam logic [7:0] OP_CMP  = 8'd1;
  localparam logic [7:0] OP_CMPI = 8'd2;
  localparam logic [7:0] OP_JMN  = 8'd3;
  localparam logic [7:0] OP_JMP  = 8'd4;
  localparam logic [7:0] OP_JM0  = 8'd5;
  localparam logic [7:0] OP_JMD0 = 8'd6;
  localparam logic [7:0] OP_MOV  = 8'd7;
  localparam logic [7:0] OP_MOVL = 8'd8;
  localparam logic [7:0] OP_MOVI = 8'd9;
  localparam logic [7:0] OP_INC  = 8'd10;
  localparam logic [7:0] OP_ADDL = 8'd11;
  localparam logic [7:0] OP_ADD  = 8'd12;

  // one input request
  typedef struct packed {
    logic [1:0]           req_type;
    logic [7:0]           mem_addr;
    logic [WORD_BITS-1:0] mem_data;
  } req_t;

  // one result
  typedef struct packed {
    logic [WORD_BITS-1:0] read_data;
    logic [7:0]           prog_counter;
    logic                 neg_flag;
    logic                 zero_flag;
    logic [7:0]           exec_opcode;
  } res_t;

  // 8-bit address to memory index, modulo the depth
  typedef logic [ADDR_BITS-1:0] wrap_tbl_t [256];

  function automatic wrap_tbl_t build_wrap();
    wrap_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = ADDR_BITS'(i % MEM_DEPTH);
    end
    return t;
  endfunction

  localparam wrap_tbl_t WRAP_TBL = build_wrap();

  function automatic logic [ADDR_BITS-1:0] wrap_addr(logic [7:0] a);
    return WRAP_TBL[a];
  endfunction

endpackage

@@ hw/rtl/m2m_ram.sv @@
// m2m_ram: generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module m2m_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write, and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/m2m_seq.sv @@
// m2m_seq: request sequencer; fetch, operand reads and write-back through
// one single-port memory. Depends on m2m_pkg and m2m_ram.
`timescale 1ns / 1ps

module m2m_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  output logic          req_stall,
  input  m2m_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output m2m_pkg::res_t res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RDW   = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_MEM1  = 3'd3;
  localparam logic [2:0] S_MEM2  = 3'd4;
  localparam logic [2:0] S_MEM3  = 3'd5;
  localparam logic [2:0] S_HOLD  = 3'd6;

  logic [2:0]                     state_r, state_nxt;
  logic [7:0]                     pc_r, pc_nxt;
  logic                           n_r, n_nxt;
  logic                           z_r, z_nxt;
  logic [m2m_pkg::WORD_BITS-1:0]  ir_r, ir_nxt;
  logic [m2m_pkg::WORD_BITS-1:0]  opa_r, opa_nxt;
  logic [m2m_pkg::WORD_BITS-1:0]  rdata_r, rdata_nxt;
  logic [7:0]                     op_r, op_nxt;

  logic                           ram_we;
  logic [m2m_pkg::ADDR_BITS-1:0]  ram_addr;
  logic [m2m_pkg::WORD_BITS-1:0]  ram_wdata;
  logic [m2m_pkg::WORD_BITS-1:0]  ram_rdata;
  logic [m2m_pkg::WORD_BITS-1:0]  diff;
  logic [7:0]                     f_op, f_a0, f_a1;
  logic [7:0]                     a0, a1;
  logic                           accept;

  // state memory
  m2m_ram #(
    .WIDTH (m2m_pkg::WORD_BITS),
    .DEPTH (m2m_pkg::MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign accept    = req_valid && (state_r == S_IDLE);
  assign req_stall = (state_r != S_IDLE);

  // fields of the word just fetched and of the held instruction
  assign f_op = ram_rdata[31:24];
  assign f_a0 = ram_rdata[23:16];
  assign f_a1 = ram_rdata[15:8];
  assign a0   = ir_r[23:16];
  assign a1   = ir_r[15:8];

  // compare subtractor
  assign diff = opa_r - ram_rdata;

  // sequencer: one memory access per cycle, so no two accesses overlap
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    n_nxt     = n_r;
    z_nxt     = z_r;
    ir_nxt    = ir_r;
    opa_nxt   = opa_r;
    rdata_nxt = rdata_r;
    op_nxt    = op_r;
    ram_we    = 1'b0;
    ram_addr  = m2m_pkg::wrap_addr(pc_r);
    ram_wdata = ram_rdata;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rdata_nxt = '0;
          op_nxt    = m2m_pkg::OP_NOP;
          case (req.req_type)
            m2m_pkg::REQ_LOAD: begin
              ram_we    = 1'b1;
              ram_addr  = m2m_pkg::wrap_addr(req.mem_addr);
              ram_wdata = req.mem_data;
              state_nxt = S_HOLD;
            end
            m2m_pkg::REQ_EXEC: begin
              ram_addr  = m2m_pkg::wrap_addr(pc_r);
              state_nxt = S_FETCH;
            end
            m2m_pkg::REQ_READ: begin
              ram_addr  = m2m_pkg::wrap_addr(req.mem_addr);
              state_nxt = S_RDW;
            end
            default: begin
              state_nxt = S_HOLD;
            end
          endcase
        end
      end
      S_RDW: begin
        rdata_nxt = ram_rdata;
        state_nxt = S_HOLD;
      end
      S_FETCH: begin
        ir_nxt    = ram_rdata;
        op_nxt    = f_op;
        pc_nxt    = pc_r + 8'd1;
        state_nxt = S_HOLD;
        case (f_op)
          m2m_pkg::OP_CMP, m2m_pkg::OP_CMPI, m2m_pkg::OP_JMN, m2m_pkg::OP_JMP,
          m2m_pkg::OP_JM0, m2m_pkg::OP_MOV, m2m_pkg::OP_MOVI, m2m_pkg::OP_INC,
          m2m_pkg::OP_ADDL: begin
            ram_addr  = m2m_pkg::wrap_addr(f_a0);
            state_nxt = S_MEM1;
          end
          m2m_pkg::OP_ADD: begin
            ram_addr  = m2m_pkg::wrap_addr(f_a1);
            state_nxt = S_MEM1;
          end
          m2m_pkg::OP_JMD0: begin
            if (z_r) begin
              pc_nxt = f_a0;
            end
          end
          m2m_pkg::OP_MOVL: begin
            ram_we    = 1'b1;
            ram_addr  = m2m_pkg::wrap_addr(f_a1);
            ram_wdata = {{(m2m_pkg::WORD_BITS-8){1'b0}}, f_a0};
            z_nxt     = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_MEM1: begin
        state_nxt = S_HOLD;
        case (op_r)
          m2m_pkg::OP_CMP, m2m_pkg::OP_CMPI: begin
            opa_nxt   = ram_rdata;
            ram_addr  = m2m_pkg::wrap_addr(a1);
            state_nxt = S_MEM2;
          end
          m2m_pkg::OP_JMN: begin
            if (n_r) begin
              pc_nxt = ram_rdata[7:0];
            end
          end
          m2m_pkg::OP_JMP: begin
            pc_nxt = ram_rdata[7:0];
          end
          m2m_pkg::OP_JM0: begin
            if (z_r) begin
              pc_nxt = ram_rdata[7:0];
            end
          end
          m2m_pkg::OP_MOV: begin
            ram_we    = 1'b1;
            ram_addr  = m2m_pkg::wrap_addr(a1);
            ram_wdata = ram_rdata;
            z_nxt     = 1'b1;
          end
          m2m_pkg::OP_MOVI: begin
            ram_addr  = m2m_pkg::wrap_addr(ram_rdata[7:0]);
            state_nxt = S_MEM2;
          end
          m2m_pkg::OP_INC: begin
            ram_we    = 1'b1;
            ram_addr  = m2m_pkg::wrap_addr(a0);
            ram_wdata = ram_rdata + 32'd1;
          end
          m2m_pkg::OP_ADDL: begin
            ram_we    = 1'b1;
            ram_addr  = m2m_pkg::wrap_addr(a0);
            ram_wdata = ram_rdata + {{(m2m_pkg::WORD_BITS-8){1'b0}}, a1};
          end
          m2m_pkg::OP_ADD: begin
            // first operand read was M[a1]
            opa_nxt   = ram_rdata;
            ram_addr  = m2m_pkg::wrap_addr(a0);
            state_nxt = S_MEM2;
          end
          default: begin
          end
        endcase
      end
      S_MEM2: begin
        state_nxt = S_HOLD;
        case (op_r)
          m2m_pkg::OP_CMP: begin
            n_nxt = diff[m2m_pkg::WORD_BITS-1];
            z_nxt = (diff == '0);
          end
          m2m_pkg::OP_CMPI: begin
            ram_addr  = m2m_pkg::wrap_addr(ram_rdata[7:0]);
            state_nxt = S_MEM3;
          end
          m2m_pkg::OP_MOVI: begin
            ram_we    = 1'b1;
            ram_addr  = m2m_pkg::wrap_addr(a1);
            ram_wdata = ram_rdata;
            z_nxt     = 1'b1;
          end
          m2m_pkg::OP_ADD: begin
            ram_we    = 1'b1;
            ram_addr  = m2m_pkg::wrap_addr(a0);
            ram_wdata = ram_rdata + opa_r;
          end
          default: begin
          end
        endcase
      end
      S_MEM3: begin
        // indirect compare, second operand arrives now
        n_nxt     = diff[m2m_pkg::WORD_BITS-1];
        z_nxt     = (diff == '0);
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= 8'd0;
      n_r     <= 1'b0;
      z_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      n_r     <= n_nxt;
      z_r     <= z_nxt;
    end
  end

  // datapath holding registers
  always_ff @(posedge clk) begin
    ir_r    <= ir_nxt;
    opa_r   <= opa_nxt;
    rdata_r <= rdata_nxt;
    op_r    <= op_nxt;
  end

  // finished result
  assign res_valid        = (state_r == S_HOLD);
  assign res.read_data    = rdata_r;
  assign res.prog_counter = pc_r;
  assign res.neg_flag     = n_r;
  assign res.zero_flag    = z_r;
  assign res.exec_opcode  = op_r;

`ifndef SYNTH
  // memory writes only from request start, the literal move or an operand state
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE || state_r == S_FETCH || state_r == S_MEM1 ||
                state_r == S_MEM2))
    else $error("memory write outside a write state");

  // a fetch always follows an accepted execute request
  a_fetch_src: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |-> ($past(state_r) == S_IDLE))
    else $error("fetch not preceded by idle");

  // pc moves only on fetch or a jump
  a_pc_move: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && pc_r != $past(pc_r)) |->
      ($past(state_r) == S_FETCH || $past(state_r) == S_MEM1))
    else $error("pc changed outside fetch or jump");

  // a waiting result stays until it is taken
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> (res_valid && $stable(rdata_r) && $stable(pc_r)))
    else $error("result dropped before transfer");
`endif

endmodule

@@ hw/rtl/memory_to_memory_cpu_step.sv @@
// memory_to_memory_cpu_step: top level; request channel, sequencer and the
// result output register. Depends on m2m_pkg, m2m_seq and m2m_ram.
//
//   channel | ports                                    | transfer when
//   --------+------------------------------------------+---------------------
//   input   | in_req_type in_mem_addr in_mem_data      | in_valid & !in_stall
//   result  | out_read_data out_prog_counter out_*_flag| out_valid & !out_stall
//           | out_exec_opcode                          |
//
// A load is one write, a read one read, an execute a fetch plus up to three
// dependent reads or a write on the single memory port, then one result.
// One request is in the sequencer at a time; a finished result moves into the
// output register, so the next request is taken while it waits.
// Synchronous active-low reset clears pc, flags and control; memory is
// undefined until loaded.
`timescale 1ns / 1ps

module memory_to_memory_cpu_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [7:0]                    in_mem_addr,
  input  logic [m2m_pkg::WORD_BITS-1:0] in_mem_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [m2m_pkg::WORD_BITS-1:0] out_read_data,
  output logic [7:0]                    out_prog_counter,
  output logic                          out_neg_flag,
  output logic                          out_zero_flag,
  output logic [7:0]                    out_exec_opcode
);

  m2m_pkg::req_t req;
  m2m_pkg::res_t res;
  m2m_pkg::res_t out_r;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid_r, out_valid_nxt;

  assign req.req_type = in_req_type;
  assign req.mem_addr = in_mem_addr;
  assign req.mem_data = in_mem_data;

  m2m_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req_stall (in_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register takes a result when empty or draining
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = out_r.read_data;
  assign out_prog_counter = out_r.prog_counter;
  assign out_neg_flag     = out_r.neg_flag;
  assign out_zero_flag    = out_r.zero_flag;
  assign out_exec_opcode  = out_r.exec_opcode;

`ifndef SYNTH
  // a new result never overwrites one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(res_valid && res_ready))
    else $error("output register overwritten while stalled");

  // a result handed over shows up at the ports on the next cycle
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> (out_valid && out_prog_counter == $past(res.prog_counter)))
    else $error("result not loaded into output register");

  // output valid rises only on a handover
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(res_valid && res_ready))
    else $error("output valid without a result");
`endif

endmodule

@@ bench/m2m_step_checker.sv @@
// m2m_step_checker: watches the request and result channels of the
// memory-to-memory processor, predicts each result and compares it.
// Depends on m2m_pkg for request codes, opcodes and the result struct.
`timescale 1ns / 1ps

module m2m_step_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    in_req_type,
  input  logic [7:0]                    in_mem_addr,
  input  logic [m2m_pkg::WORD_BITS-1:0] in_mem_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [m2m_pkg::WORD_BITS-1:0] out_read_data,
  input  logic [7:0]                    out_prog_counter,
  input  logic                          out_neg_flag,
  input  logic                          out_zero_flag,
  input  logic [7:0]                    out_exec_opcode,
  output int                            fail_count,
  output int                            pending_count,
  output int                            checked_count,
  output int                            exec_count
);

  // shadow copy of the processor state
  logic [m2m_pkg::WORD_BITS-1:0] cpu_mem [m2m_pkg::MEM_DEPTH];
  logic [7:0]                    cpu_pc;
  logic                          cpu_n;
  logic                          cpu_z;

  // results still owed by the block, oldest first
  m2m_pkg::res_t owed_results [$];
  m2m_pkg::res_t seen_res;
  m2m_pkg::res_t want_res;
  m2m_pkg::res_t next_res;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
    exec_count    = 0;
    cpu_pc        = 8'd0;
    cpu_n         = 1'b0;
    cpu_z         = 1'b0;
    for (int i = 0; i < m2m_pkg::MEM_DEPTH; i++) begin
      cpu_mem[i] = '0;
    end
  end

  // 8-bit address to memory slot
  function automatic int slot(input logic [7:0] a);
    return int'(a) % m2m_pkg::MEM_DEPTH;
  endfunction

  function automatic logic [m2m_pkg::WORD_BITS-1:0] mem_at(input logic [7:0] a);
    return cpu_mem[slot(a)];
  endfunction

  task automatic compare_flags(input logic [m2m_pkg::WORD_BITS-1:0] a,
                               input logic [m2m_pkg::WORD_BITS-1:0] b);
    logic [m2m_pkg::WORD_BITS-1:0] diff;
    diff  = a - b;
    cpu_n = diff[m2m_pkg::WORD_BITS-1];
    cpu_z = (diff == '0);
  endtask

  // apply one request to the shadow state and form its result
  task automatic apply_request(input logic [1:0] req, input logic [7:0] addr,
                               input logic [m2m_pkg::WORD_BITS-1:0] data,
                               output m2m_pkg::res_t r);
    logic [m2m_pkg::WORD_BITS-1:0] word;
    logic [m2m_pkg::WORD_BITS-1:0] ptr;
    logic [7:0]                    op;
    logic [7:0]                    a0;
    logic [7:0]                    a1;
    r = '0;
    case (req)
      m2m_pkg::REQ_LOAD: cpu_mem[slot(addr)] = data;
      m2m_pkg::REQ_READ: r.read_data = mem_at(addr);
      m2m_pkg::REQ_EXEC: begin
        word   = mem_at(cpu_pc);
        op     = word[31:24];
        a0     = word[23:16];
        a1     = word[15:8];
        cpu_pc = cpu_pc + 8'd1;
        case (op)
          m2m_pkg::OP_CMP: compare_flags(mem_at(a0), mem_at(a1));
          m2m_pkg::OP_CMPI: begin
            ptr = mem_at(a1);
            compare_flags(mem_at(a0), mem_at(ptr[7:0]));
          end
          m2m_pkg::OP_JMN: begin
            ptr = mem_at(a0);
            if (cpu_n) cpu_pc = ptr[7:0];
          end
          m2m_pkg::OP_JMP: begin
            ptr    = mem_at(a0);
            cpu_pc = ptr[7:0];
          end
          m2m_pkg::OP_JM0: begin
            ptr = mem_at(a0);
            if (cpu_z) cpu_pc = ptr[7:0];
          end
          m2m_pkg::OP_JMD0: begin
            if (cpu_z) cpu_pc = a0;
          end
          m2m_pkg::OP_MOV: begin
            cpu_mem[slot(a1)] = mem_at(a0);
            cpu_z             = 1'b1;
          end
          m2m_pkg::OP_MOVL: begin
            cpu_mem[slot(a1)] = m2m_pkg::WORD_BITS'(a0);
            cpu_z             = 1'b1;
          end
          m2m_pkg::OP_MOVI: begin
            ptr               = mem_at(a0);
            cpu_mem[slot(a1)] = mem_at(ptr[7:0]);
            cpu_z             = 1'b1;
          end
          m2m_pkg::OP_INC:  cpu_mem[slot(a0)] = mem_at(a0) + m2m_pkg::WORD_BITS'(1);
          m2m_pkg::OP_ADDL: cpu_mem[slot(a0)] = mem_at(a0) + m2m_pkg::WORD_BITS'(a1);
          m2m_pkg::OP_ADD:  cpu_mem[slot(a0)] = mem_at(a0) + mem_at(a1);
          // nop and opcodes past the table only advance the pc
          default: ;
        endcase
        r.exec_opcode = op;
      end
      // unused request code leaves the state alone
      default: ;
    endcase
    r.prog_counter = cpu_pc;
    r.neg_flag     = cpu_n;
    r.zero_flag    = cpu_z;
  endtask

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("checker: %s: got %h, expected %h (after %0d results)",
             what, got, want, checked_count);
  endtask

  // result side first, then the request side of the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_res.read_data    = out_read_data;
        seen_res.prog_counter = out_prog_counter;
        seen_res.neg_flag     = out_neg_flag;
        seen_res.zero_flag    = out_zero_flag;
        seen_res.exec_opcode  = out_exec_opcode;
        if (owed_results.size() == 0) begin
          report_mismatch("result with no request pending", out_read_data, '0);
        end else begin
          want_res = owed_results.pop_front();
          if (seen_res.read_data !== want_res.read_data)
            report_mismatch("read_data", seen_res.read_data, want_res.read_data);
          if (seen_res.prog_counter !== want_res.prog_counter)
            report_mismatch("prog_counter", 32'(seen_res.prog_counter),
                            32'(want_res.prog_counter));
          if (seen_res.neg_flag !== want_res.neg_flag)
            report_mismatch("neg_flag", 32'(seen_res.neg_flag), 32'(want_res.neg_flag));
          if (seen_res.zero_flag !== want_res.zero_flag)
            report_mismatch("zero_flag", 32'(seen_res.zero_flag), 32'(want_res.zero_flag));
          if (seen_res.exec_opcode !== want_res.exec_opcode)
            report_mismatch("exec_opcode", 32'(seen_res.exec_opcode),
                            32'(want_res.exec_opcode));
          checked_count++;
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(in_req_type, in_mem_addr, in_mem_data, next_res);
        owed_results.push_back(next_res);
        if (in_req_type == m2m_pkg::REQ_EXEC) exec_count++;
      end
      pending_count = owed_results.size();
    end
  end

endmodule

@@ bench/memory_to_memory_cpu_step_tb.sv @@
// memory_to_memory_cpu_step_tb: drives requests into the processor, stalls
// its result channel and reports the verdict. Depends on m2m_pkg, the block
// and m2m_step_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module memory_to_memory_cpu_step_tb;

  localparam logic [1:0] REQ_NONE    = 2'd3;
  localparam int         HOLD_CYCLES = 300;
  localparam int         PHASE_ITEMS = 404;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    in_req_type;
  logic [7:0]                    in_mem_addr;
  logic [m2m_pkg::WORD_BITS-1:0] in_mem_data;
  logic                          out_valid;
  logic                          out_stall;
  logic [m2m_pkg::WORD_BITS-1:0] out_read_data;
  logic [7:0]                    out_prog_counter;
  logic                          out_neg_flag;
  logic                          out_zero_flag;
  logic [7:0]                    out_exec_opcode;

  int fail_count;
  int pending_count;
  int checked_count;
  int exec_count;

  int   idle_pct;
  int   stall_pct;
  int   sent_count;
  logic hold_kick;
  logic hold_taken;
  int   hold_left;

  memory_to_memory_cpu_step u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_mem_addr      (in_mem_addr),
    .in_mem_data      (in_mem_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_prog_counter (out_prog_counter),
    .out_neg_flag     (out_neg_flag),
    .out_zero_flag    (out_zero_flag),
    .out_exec_opcode  (out_exec_opcode)
  );

  m2m_step_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_mem_addr      (in_mem_addr),
    .in_mem_data      (in_mem_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_prog_counter (out_prog_counter),
    .out_neg_flag     (out_neg_flag),
    .out_zero_flag    (out_zero_flag),
    .out_exec_opcode  (out_exec_opcode),
    .fail_count       (fail_count),
    .pending_count    (pending_count),
    .checked_count    (checked_count),
    .exec_count       (exec_count)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // result side: random stall, plus one long hold-off when kicked
  always @(posedge clk) begin
    if (hold_kick && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // run limit
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [31:0] instr(input logic [7:0] op, input logic [7:0] a0,
                                        input logic [7:0] a1, input logic [7:0] a2);
    return {op, a0, a1, a2};
  endfunction

  // operand addresses cluster so that operands alias often
  function automatic logic [7:0] pick_operand();
    case ($urandom_range(3))
      0:       return 8'($urandom);
      1:       return 8'hF0 + 8'($urandom_range(15));
      default: return 8'($urandom_range(31));
    endcase
  endfunction

  // mostly valid instructions, some opcodes past the table, some plain data
  function automatic logic [31:0] memory_word();
    logic [7:0] op;
    logic [7:0] a0;
    logic [7:0] a1;
    if ($urandom_range(9) < 6) begin
      op = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 13)) : 8'($urandom_range(12));
      a0 = pick_operand();
      a1 = ($urandom_range(7) == 0) ? a0 : pick_operand();
      return instr(op, a0, a1, 8'($urandom));
    end
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($urandom_range(255));
      2:       return 32'hFFFF_FF00 | 32'($urandom_range(255));
      default: begin
        case ($urandom_range(3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // offer one request and hold it until the transfer
  task automatic send_req(input logic [1:0] req, input logic [7:0] addr,
                          input logic [31:0] data);
    bit done;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_mem_addr <= addr;
    in_mem_data <= data;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      done = !in_stall;
      @(posedge clk);
    end
    sent_count++;
  endtask

  initial begin
    int counted;
    int pick;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_req_type = m2m_pkg::REQ_LOAD;
    in_mem_addr = 8'd0;
    in_mem_data = '0;
    out_stall   = 1'b0;
    hold_kick   = 1'b0;
    hold_taken  = 1'b0;
    hold_left   = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    sent_count  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed program: every opcode, jumps taken, wraps, opcode past the table
    send_req(m2m_pkg::REQ_LOAD, 8'h00, instr(m2m_pkg::OP_CMP,  8'h00, 8'h01, 8'h00));
    send_req(m2m_pkg::REQ_LOAD, 8'h01, instr(m2m_pkg::OP_JMN,  8'h01, 8'h00, 8'h03));
    send_req(m2m_pkg::REQ_LOAD, 8'h03, instr(m2m_pkg::OP_CMPI, 8'h03, 8'h03, 8'h03));
    send_req(m2m_pkg::REQ_LOAD, 8'h04, instr(m2m_pkg::OP_JMD0, 8'h06, 8'h00, 8'h00));
    send_req(m2m_pkg::REQ_LOAD, 8'h06, instr(m2m_pkg::OP_JM0,  8'h06, 8'h00, 8'h08));
    send_req(m2m_pkg::REQ_LOAD, 8'h08, instr(m2m_pkg::OP_JMP,  8'h08, 8'h00, 8'h0A));
    send_req(m2m_pkg::REQ_LOAD, 8'h0A, 32'hFFFF_FFFF);
    send_req(m2m_pkg::REQ_LOAD, 8'h0B, instr(m2m_pkg::OP_MOV,  8'h0A, 8'hF0, 8'h00));
    send_req(m2m_pkg::REQ_LOAD, 8'h0C, instr(m2m_pkg::OP_MOVL, 8'hFF, 8'hF1, 8'h00));
    send_req(m2m_pkg::REQ_LOAD, 8'h0D, instr(m2m_pkg::OP_MOVI, 8'h06, 8'hF2, 8'h00));
    send_req(m2m_pkg::REQ_LOAD, 8'h0E, instr(m2m_pkg::OP_INC,  8'hF0, 8'h00, 8'h00));
    send_req(m2m_pkg::REQ_LOAD, 8'h0F, instr(m2m_pkg::OP_ADDL, 8'hF1, 8'hFF, 8'h00));
    send_req(m2m_pkg::REQ_LOAD, 8'h10, instr(m2m_pkg::OP_ADD,  8'h0A, 8'h0A, 8'h00));
    send_req(m2m_pkg::REQ_LOAD, 8'h11, instr(m2m_pkg::OP_NOP,  8'h00, 8'h00, 8'h00));
    repeat (14) send_req(m2m_pkg::REQ_EXEC, 8'($urandom), $urandom);
    send_req(m2m_pkg::REQ_READ, 8'h0A, $urandom);
    send_req(REQ_NONE, 8'hFF, 32'hFFFF_FFFF);

    // fill every word so that no later request touches unwritten memory
    for (int a = 0; a < 256; a++) begin
      send_req(m2m_pkg::REQ_LOAD, 8'(a), memory_word());
    end

    // random mix over four idle/stall phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct <= 0;  end
        1:       begin idle_pct = 73; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 73; end
        default: begin idle_pct = 7;  stall_pct <= 7;  end
      endcase
      // long result hold-off while requests keep coming
      if (phase == 0) hold_kick <= 1'b1;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          send_req(m2m_pkg::REQ_EXEC, 8'($urandom), $urandom);
          counted++;
        end else if (pick < 80) begin
          send_req(m2m_pkg::REQ_LOAD, 8'($urandom), memory_word());
          counted++;
        end else if (pick < 95) begin
          send_req(m2m_pkg::REQ_READ, 8'($urandom), $urandom);
          counted++;
        end else begin
          send_req(REQ_NONE, 8'($urandom), $urandom);
        end
      end
    end
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("summary: %0d requests sent, %0d executes, %0d results checked",
             sent_count, exec_count, checked_count);
    $display("summary: four idle/stall phases and a %0d-cycle result hold-off, %0d mismatches",
             HOLD_CYCLES, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ memory_to_memory_cpu_step.f @@
hw/rtl/m2m_pkg.sv
hw/rtl/m2m_ram.sv
hw/rtl/m2m_seq.sv
hw/rtl/memory_to_memory_cpu_step.sv
bench/m2m_step_checker.sv
bench/memory_to_memory_cpu_step_tb.sv
